// ===== design/phich_reg_group_mapper_macros.svh =====
// Assertion helpers shared by the mapper files.
// Each macro expects clk and rst_n in scope.
`ifndef PHICH_REG_GROUP_MAPPER_MACROS_SVH
`define PHICH_REG_GROUP_MAPPER_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/phich_rgm_pkg.sv =====
package phich_rgm_pkg;

    // Port widths
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 32;
    localparam int IN_TDATA_W   = 8;
    localparam int OUT_TDATA_W  = 40;

    // Field widths
    localparam int RB_W         = 7;
    localparam int CELL_W       = 9;
    localparam int RES_W        = 4;
    localparam int GROUP_W      = 6;
    localparam int TOTAL_W      = 6;
    localparam int REG_W        = 9;
    localparam int PCFICH_W     = 32;
    localparam int POS_W        = 8;
    localparam int SLOT_W       = 2;

    // Internal widths
    localparam int N0_W         = 8;
    localparam int N1_W         = 9;
    localparam int SUM_W        = 10;
    localparam int PROD_W       = 11;
    localparam int THIRD_IN_W   = 10;
    localparam int THIRD_PROD_W = 20;

    // Constants of the mapping
    localparam int RB_MIN          = 6;
    localparam int RB_MAX          = 110;
    localparam int RES_MAX         = 12;
    localparam int N0_OFFSET       = 4;
    localparam int GROUP_ROUND     = 47;   // ceil(x/48) = floor((x+47)/16/3)
    localparam int GROUP_DIV_SHIFT = 4;
    localparam int THIRD_MULT      = 683;  // floor(x/3) = (x*683)>>11 for x < 2048
    localparam int THIRD_SHIFT     = 11;

    // Iterative divider
    localparam int DIV_DIVD_W   = 18;
    localparam int DIV_DIVS_W   = 9;
    localparam int DIV_STEPS    = DIV_DIVD_W;
    localparam int DIV_CNT_W    = $clog2(DIV_STEPS + 1);

    // Pipeline
    localparam int PIPE_STAGES  = 5;
    localparam int LANES        = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RB_COUNT      = 3'd0,
        CFG_CELL_ID       = 3'd1,
        CFG_RESOURCE      = 3'd2,
        CFG_EXT_PREFIX    = 3'd3,
        CFG_EXT_DURATION  = 3'd4,
        CFG_PCFICH_POS    = 3'd5,
        CFG_PCFICH_FIRST  = 3'd6
    } cfg_index_t;

    typedef enum logic [2:0] {
        PREP_SETUP,
        PREP_THIRDS,
        PREP_DIV_CELL,
        PREP_DIV_SCALE,
        PREP_DIV_WRAP,
        PREP_READY
    } prep_state_t;

    typedef struct packed {
        logic [N0_W-1:0]     n0;
        logic [N1_W-1:0]     n1;
        logic [N0_W-1:0]     n0_third;
        logic [N0_W-1:0]     n0_two_third;
        logic [N1_W-1:0]     n1_third;
        logic [N1_W-1:0]     n1_two_third;
        logic [N0_W-1:0]     cell_mod;
        logic [N1_W-1:0]     scaled_mod;
        logic [GROUP_W-1:0]  base;
        logic [TOTAL_W-1:0]  total;
        logic                ext_duration;
        logic [PCFICH_W-1:0] pcfich_pos;
        logic [SLOT_W-1:0]   pcfich_first;
    } derived_t;

    typedef struct packed {
        logic                  start;
        logic [DIV_DIVD_W-1:0] dividend;
        logic [DIV_DIVS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                  done;
        logic [DIV_DIVD_W-1:0] quotient;
        logic [DIV_DIVS_W-1:0] remainder;
    } div_resp_t;

    function automatic logic [THIRD_IN_W-1:0] div3(input logic [THIRD_IN_W-1:0] x);
        logic [THIRD_PROD_W-1:0] p;
        p = THIRD_PROD_W'(x) * THIRD_PROD_W'(THIRD_MULT);
        return THIRD_IN_W'(p >> THIRD_SHIFT);
    endfunction

    function automatic logic [POS_W-1:0] pcfich_at(input logic [PCFICH_W-1:0] pos,
                                                   input logic [SLOT_W-1:0]   slot);
        return pos[{slot, 3'b000} +: POS_W];
    endfunction

    // Step past one PCFICH REG
    function automatic logic [REG_W-1:0] skip_step(input logic [REG_W-1:0] r,
                                                   input logic [POS_W-1:0] pos);
        return (r >= REG_W'(pos)) ? r + REG_W'(1) : r;
    endfunction

    function automatic logic [SUM_W-1:0] wrap_once(input logic [SUM_W-1:0] s,
                                                   input logic [SUM_W-1:0] m);
        return (s >= m) ? s - m : s;
    endfunction

endpackage

// ===== design/phich_rgm_div.sv =====
module phich_rgm_div
    import phich_rgm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  div_req_t  req,
    output div_resp_t resp
);

    logic [DIV_DIVD_W-1:0] quo_reg;
    logic [DIV_DIVS_W-1:0] rem_reg;
    logic [DIV_DIVS_W-1:0] divisor_reg;
    logic [DIV_CNT_W-1:0]  count_reg;
    logic                  run_reg;
    logic                  done_reg;

    logic [DIV_DIVS_W:0]   partial;
    logic                  fits;

    always_comb
    begin
        partial = {rem_reg, quo_reg[DIV_DIVD_W-1]};
        fits    = partial >= {1'b0, divisor_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg   <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else if (req.start)
        begin
            run_reg   <= 1'b1;
            done_reg  <= 1'b0;
            count_reg <= DIV_CNT_W'(DIV_STEPS);
        end
        else if (run_reg)
        begin
            count_reg <= count_reg - DIV_CNT_W'(1);
            if (count_reg == DIV_CNT_W'(1))
            begin
                run_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // Shift dividend out and quotient bits in, one bit per cycle
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg     <= req.dividend;
            rem_reg     <= '0;
            divisor_reg <= req.divisor;
        end
        else if (run_reg)
        begin
            quo_reg <= {quo_reg[DIV_DIVD_W-2:0], fits};
            rem_reg <= fits ? DIV_DIVS_W'(partial - {1'b0, divisor_reg})
                            : partial[DIV_DIVS_W-1:0];
        end
    end

    assign resp.done      = done_reg;
    assign resp.quotient  = quo_reg;
    assign resp.remainder = rem_reg;

endmodule

// ===== design/phich_rgm_prep.sv =====
module phich_rgm_prep
    import phich_rgm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output derived_t              derived,
    output logic                  busy
);

    logic [RB_W-1:0]     rb_count_reg;
    logic [CELL_W-1:0]   cell_id_reg;
    logic [RES_W-1:0]    resource_reg;
    logic                ext_prefix_reg;
    logic                ext_duration_reg;
    logic [PCFICH_W-1:0] pcfich_pos_reg;
    logic [SLOT_W-1:0]   pcfich_first_reg;

    prep_state_t         state_reg, state_next;
    derived_t            derived_reg, derived_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;

    logic [RB_W-1:0]     rbs_c;
    logic [RES_W-1:0]    res_c;
    logic [PROD_W-1:0]   prod_round;

    div_req_t            div_req;
    div_resp_t           div_resp;

    phich_rgm_div u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (div_req),
        .resp (div_resp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rb_count_reg     <= RB_W'(RB_MIN);
            cell_id_reg      <= '0;
            resource_reg     <= RES_W'(1);
            ext_prefix_reg   <= 1'b0;
            ext_duration_reg <= 1'b0;
            pcfich_pos_reg   <= '0;
            pcfich_first_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_RB_COUNT:     rb_count_reg     <= cfg_data[RB_W-1:0];
                CFG_CELL_ID:      cell_id_reg      <= cfg_data[CELL_W-1:0];
                CFG_RESOURCE:     resource_reg     <= cfg_data[RES_W-1:0];
                CFG_EXT_PREFIX:   ext_prefix_reg   <= cfg_data[0];
                CFG_EXT_DURATION: ext_duration_reg <= cfg_data[0];
                CFG_PCFICH_POS:   pcfich_pos_reg   <= cfg_data[PCFICH_W-1:0];
                CFG_PCFICH_FIRST: pcfich_first_reg <= cfg_data[SLOT_W-1:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= PREP_SETUP;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        derived_reg <= derived_next;
        prod_reg    <= prod_next;
    end

    always_comb
    begin
        if (rb_count_reg < RB_W'(RB_MIN))
            rbs_c = RB_W'(RB_MIN);
        else if (rb_count_reg > RB_W'(RB_MAX))
            rbs_c = RB_W'(RB_MAX);
        else
            rbs_c = rb_count_reg;
        res_c      = (resource_reg > RES_W'(RES_MAX)) ? RES_W'(RES_MAX) : resource_reg;
        prod_round = prod_reg + PROD_W'(GROUP_ROUND);
    end

    always_comb
    begin
        state_next       = state_reg;
        derived_next     = derived_reg;
        prod_next        = prod_reg;
        div_req.start    = 1'b0;
        div_req.dividend = DIV_DIVD_W'(cell_id_reg);
        div_req.divisor  = DIV_DIVS_W'(derived_reg.n0);

        case (state_reg)
            PREP_SETUP:
            begin
                derived_next.n0           = N0_W'({rbs_c, 1'b0}) - N0_W'(N0_OFFSET);
                derived_next.n1           = N1_W'({rbs_c, 1'b0}) + N1_W'(rbs_c);
                derived_next.ext_duration = ext_duration_reg;
                derived_next.pcfich_pos   = pcfich_pos_reg;
                derived_next.pcfich_first = pcfich_first_reg;
                prod_next                 = PROD_W'(res_c) * PROD_W'(rbs_c);
                state_next                = PREP_THIRDS;
            end
            PREP_THIRDS:
            begin
                derived_next.n0_third     = N0_W'(div3(THIRD_IN_W'(derived_reg.n0)));
                derived_next.n0_two_third =
                    N0_W'(div3(THIRD_IN_W'({derived_reg.n0, 1'b0})));
                derived_next.n1_third     = N1_W'(div3(THIRD_IN_W'(derived_reg.n1)));
                derived_next.n1_two_third =
                    N1_W'(div3(THIRD_IN_W'({derived_reg.n1, 1'b0})));
                derived_next.base         =
                    GROUP_W'(div3(THIRD_IN_W'(prod_round >> GROUP_DIV_SHIFT)));
                derived_next.total        = ext_prefix_reg ?
                    TOTAL_W'({derived_next.base, 1'b0}) : TOTAL_W'(derived_next.base);
                // cell_id mod n0
                div_req.start             = 1'b1;
                state_next                = PREP_DIV_CELL;
            end
            PREP_DIV_CELL:
            begin
                if (div_resp.done)
                begin
                    derived_next.cell_mod = N0_W'(div_resp.remainder);
                    // floor(cell_id * n1 / n0)
                    div_req.start         = 1'b1;
                    div_req.dividend      =
                        DIV_DIVD_W'(cell_id_reg) * DIV_DIVD_W'(derived_reg.n1);
                    state_next            = PREP_DIV_SCALE;
                end
            end
            PREP_DIV_SCALE:
            begin
                if (div_resp.done)
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = div_resp.quotient;
                    div_req.divisor  = DIV_DIVS_W'(derived_reg.n1);
                    state_next       = PREP_DIV_WRAP;
                end
            end
            PREP_DIV_WRAP:
            begin
                if (div_resp.done)
                begin
                    derived_next.scaled_mod = N1_W'(div_resp.remainder);
                    state_next              = PREP_READY;
                end
            end
            PREP_READY:
            begin
                state_next = PREP_READY;
            end
            default:
            begin
                state_next = PREP_SETUP;
            end
        endcase

        // Any write restarts the setup sequence
        if (cfg_write)
            state_next = PREP_SETUP;
    end

    assign derived = derived_reg;
    assign busy    = (state_reg != PREP_READY);

endmodule

// ===== design/phich_rgm_pipe.sv =====
module phich_rgm_pipe
    import phich_rgm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  derived_t           derived,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [GROUP_W-1:0] group_index,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [REG_W-1:0]   reg_first,
    output logic [REG_W-1:0]   reg_second,
    output logic [REG_W-1:0]   reg_third,
    output logic [TOTAL_W-1:0] group_total,
    output logic               group_valid
);

    logic [PIPE_STAGES-1:0] v_reg;
    logic [PIPE_STAGES-1:0] rdy;

    logic [SUM_W-1:0]   sum1_reg [LANES];
    logic [SUM_W-1:0]   sum2_reg [LANES];
    logic [REG_W-1:0]   reg3_reg [LANES];
    logic [REG_W-1:0]   reg4_reg [LANES];
    logic [REG_W-1:0]   reg5_reg [LANES];
    logic               gv1_reg, gv2_reg, gv3_reg, gv4_reg, gv5_reg;
    logic [TOTAL_W-1:0] total5_reg;

    logic [SUM_W-1:0]   sum1_next [LANES];
    logic [SUM_W-1:0]   sum2_next [LANES];
    logic [REG_W-1:0]   reg3_next [LANES];
    logic [REG_W-1:0]   reg4_next [LANES];
    logic [REG_W-1:0]   reg5_next [LANES];
    logic [SUM_W-1:0]   modulus   [LANES];
    logic [REG_W-1:0]   start_c   [LANES];
    logic [REG_W-1:0]   offset_c  [LANES];
    logic               skip4, skip5;
    logic [SLOT_W-1:0]  slot_a, slot_b, slot_c, slot_d;

    // A stage advances when it is empty or the one after it advances
    always_comb
    begin
        rdy[PIPE_STAGES-1] = !v_reg[PIPE_STAGES-1] || out_ready;
        for (int i = PIPE_STAGES - 2; i >= 0; i--)
            rdy[i] = !v_reg[i] || rdy[i+1];
    end

    assign in_ready = rdy[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
        begin
            if (rdy[0])
                v_reg[0] <= in_valid;
            for (int i = 1; i < PIPE_STAGES; i++)
                if (rdy[i])
                    v_reg[i] <= v_reg[i-1];
        end
    end

    always_comb
    begin
        modulus[0]  = SUM_W'(derived.n0);
        modulus[1]  = derived.ext_duration ? SUM_W'(derived.n1) : SUM_W'(derived.n0);
        modulus[2]  = modulus[1];
        start_c[0]  = REG_W'(derived.cell_mod);
        start_c[1]  = derived.ext_duration ? REG_W'(derived.scaled_mod)
                                           : REG_W'(derived.cell_mod);
        start_c[2]  = start_c[1];
        offset_c[0] = '0;
        offset_c[1] = derived.ext_duration ? REG_W'(derived.n1_third)
                                           : REG_W'(derived.n0_third);
        offset_c[2] = derived.ext_duration ? REG_W'(derived.n1_two_third)
                                           : REG_W'(derived.n0_two_third);

        slot_a = derived.pcfich_first;
        slot_b = derived.pcfich_first + SLOT_W'(1);
        slot_c = derived.pcfich_first + SLOT_W'(2);
        slot_d = derived.pcfich_first + SLOT_W'(3);
        skip4  = gv3_reg && !derived.ext_duration;
        skip5  = gv4_reg && !derived.ext_duration;

        for (int l = 0; l < LANES; l++)
        begin
            // For a valid group the sum stays below three times the modulus: two wrap steps suffice
            sum1_next[l] = SUM_W'(start_c[l]) + SUM_W'(group_index) + SUM_W'(offset_c[l]);
            sum2_next[l] = wrap_once(sum1_reg[l], modulus[l]);
            reg3_next[l] = gv2_reg ? REG_W'(wrap_once(sum2_reg[l], modulus[l])) : '0;
            reg4_next[l] = skip4 ?
                skip_step(skip_step(reg3_reg[l], pcfich_at(derived.pcfich_pos, slot_a)),
                          pcfich_at(derived.pcfich_pos, slot_b)) : reg3_reg[l];
            reg5_next[l] = skip5 ?
                skip_step(skip_step(reg4_reg[l], pcfich_at(derived.pcfich_pos, slot_c)),
                          pcfich_at(derived.pcfich_pos, slot_d)) : reg4_reg[l];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            sum1_reg <= sum1_next;
            gv1_reg  <= group_index < derived.base;
        end
        if (rdy[1])
        begin
            sum2_reg <= sum2_next;
            gv2_reg  <= gv1_reg;
        end
        if (rdy[2])
        begin
            reg3_reg <= reg3_next;
            gv3_reg  <= gv2_reg;
        end
        if (rdy[3])
        begin
            reg4_reg <= reg4_next;
            gv4_reg  <= gv3_reg;
        end
        if (rdy[4])
        begin
            reg5_reg   <= reg5_next;
            gv5_reg    <= gv4_reg;
            total5_reg <= derived.total;
        end
    end

    assign out_valid   = v_reg[PIPE_STAGES-1];
    assign reg_first   = reg5_reg[0];
    assign reg_second  = reg5_reg[1];
    assign reg_third   = reg5_reg[2];
    assign group_total = total5_reg;
    assign group_valid = gv5_reg;

endmodule

// ===== design/phich_reg_group_mapper.sv =====
// The result of an input transaction passes through five register stages.
// The five-stage pipeline takes one group index per cycle unless m_axis_tready
// back-pressure or a setup pass holds it. Reset (rst_n, asynchronous) and every register
// write start a setup pass that fills the derived tables through a shared 18-step divider,
// with s_axis_tready low; register writes are taken at all times.
`include "phich_reg_group_mapper_macros.svh"

module phich_reg_group_mapper
    import phich_rgm_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,

    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [5:0] group_index, [7:6] zero
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,

    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [8:0] reg_first, [17:9] reg_second, [26:18] reg_third,
    // [32:27] group_total, [39:33] zero
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // [0] group_valid
    output logic                   m_axis_tuser
);

    derived_t           derived;
    logic               prep_busy;
    logic               pipe_ready;
    logic [REG_W-1:0]   reg_first, reg_second, reg_third;
    logic [TOTAL_W-1:0] group_total;
    logic               group_valid;

    assign cfg_ready = 1'b1;

    phich_rgm_prep u_prep (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_write(cfg_valid && cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .derived  (derived),
        .busy     (prep_busy)
    );

    phich_rgm_pipe u_pipe (
        .clk        (clk),
        .rst_n      (rst_n),
        .derived    (derived),
        .in_valid   (s_axis_tvalid && !prep_busy),
        .in_ready   (pipe_ready),
        .group_index(s_axis_tdata[GROUP_W-1:0]),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .reg_first  (reg_first),
        .reg_second (reg_second),
        .reg_third  (reg_third),
        .group_total(group_total),
        .group_valid(group_valid)
    );

    // Hold input while the derived tables are rebuilt
    assign s_axis_tready = pipe_ready && !prep_busy;

    assign m_axis_tdata = {(OUT_TDATA_W - 3 * REG_W - TOTAL_W)'(0),
                           group_total, reg_third, reg_second, reg_first};
    assign m_axis_tuser = group_valid;

    `ASSERT_IMPLIES(a_invalid_group_zero, m_axis_tvalid && !m_axis_tuser, m_axis_tdata[3*REG_W-1:0] == '0, "invalid group carries nonzero REG index")
    `ASSERT_NEXT(a_write_holds_input, cfg_valid && cfg_ready, !s_axis_tready, "input ready right after a register write")

endmodule
